/* rtl/core/bmpi_pkg.sv */
// Shared types and constants of the bus-mouse PPI interface.
`timescale 1ns / 1ps
package bmpi_pkg;

   localparam int CNT_W   = 16;
   localparam int DIV_W   = 34;
   localparam int DVS_W   = 16;
   localparam int K_W     = 22;
   localparam int SMP_W   = 12;
   localparam int DCNT_W  = $clog2(DIV_W + 1);

   // elapsed/1000 as ((elapsed >> 3) * K_RECIP) >> K_POST_SHIFT, exact below 2^31
   localparam int          K_PRE_SHIFT  = 3;
   localparam int          K_POST_SHIFT = 35;
   localparam int          K_RECIP_W    = 29;
   localparam int          KPROD_W      = 57;
   localparam logic [28:0] K_RECIP      = 29'd274877907;

   localparam logic [1:0] CMD_READ   = 2'd0;
   localparam logic [1:0] CMD_WRITE  = 2'd1;
   localparam logic [1:0] CMD_MOTION = 2'd2;
   localparam logic [1:0] CMD_TICK   = 2'd3;

   localparam logic [2:0] PORT_A    = 3'd0;
   localparam logic [2:0] PORT_B    = 3'd1;
   localparam logic [2:0] PORT_C    = 3'd2;
   localparam logic [2:0] PORT_CTRL = 3'd3;
   localparam logic [2:0] PORT_TIME = 3'd4;

   localparam logic [2:0] REG_RAPID  = 3'd0;
   localparam logic [2:0] REG_MOVE   = 3'd1;
   localparam logic [2:0] REG_INTR   = 3'd2;
   localparam logic [2:0] REG_DIP2   = 3'd3;
   localparam logic [2:0] REG_DIP0   = 3'd4;

   localparam logic [31:0] MOVE_MIN_CLOCKS = 32'd2000;
   localparam logic [15:0] CLOCKS_PER_K    = 16'd1000;
   localparam logic [7:0]  RAPID_BITS      = 8'ha0;
   localparam logic [7:0]  PORTA_FIXED     = 8'h40;
   localparam logic [7:0]  PORTB_FIXED     = 8'h40;
   localparam logic [7:0]  MODE_RESET      = 8'h93;
   localparam logic [7:0]  PORTC_RESET     = 8'hf0;
   localparam logic [7:0]  PORTC_LOW_MASK  = 8'h1f;
   localparam logic [7:0]  PORTC_FIXED     = 8'h08;
   localparam logic [7:0]  OPEN_BUS        = 8'hff;

   typedef struct packed {
      logic        rapid_enable;
      logic [15:0] move_clock_period;
      logic [23:0] intr_clock_period;
      logic [7:0]  dip_switch_two;
      logic [7:0]  dip_switch_zero;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic timer;
      logic div_start;
      logic div_k;
      logic lat_k;
      logic mul_x;
      logic lat_x;
      logic mul_y;
      logic lat_y;
      logic apply;
      logic exec;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic need_update;
      logic div_done;
   } dp_stat_type;

endpackage

/* rtl/core/bmpi_divider.sv */
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module bmpi_divider
   import bmpi_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic [DIV_W-1:0] quotient,
   output logic             done
);

   logic [DIV_W-1:0]  quo_ff;
   logic [DVS_W-1:0]  rem_ff;
   logic [DVS_W-1:0]  dvs_ff;
   logic [DCNT_W-1:0] cnt_ff;
   logic              done_ff;
   logic [DVS_W:0]    shifted;
   logic [DVS_W:0]    trial;
   logic              fits;

   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         cnt_ff  <= DCNT_W'(DIV_W);
         done_ff <= 1'b0;
      end else if (cnt_ff != '0) begin
         cnt_ff  <= cnt_ff - 1'b1;
         done_ff <= (cnt_ff == DCNT_W'(1));
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (cnt_ff != '0) begin
         quo_ff <= {quo_ff[DIV_W-2:0], fits};
         rem_ff <= fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

/* rtl/core/bmpi_datapath.sv */
// Datapath: PPI ports, motion counters, interrupt timer and result register.
`timescale 1ns / 1ps
module bmpi_datapath
   import bmpi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   input  logic [1:0]  in_command,
   input  logic [2:0]  in_port_select,
   input  logic [7:0]  in_write_data,
   input  logic [31:0] in_now,
   input  logic signed [11:0] in_motion_x,
   input  logic signed [11:0] in_motion_y,
   input  logic [7:0]  in_buttons,
   output logic [7:0]  out_read_data,
   output logic        out_irq
);

   logic [1:0]  cmd_ff;
   logic [2:0]  port_ff;
   logic [7:0]  data_ff;
   logic [31:0] now_ff;
   logic signed [SMP_W-1:0] mx_ff, my_ff;
   logic [7:0]  btn_ff;

   logic [CNT_W-1:0] count_x_ff, count_y_ff;
   logic signed [SMP_W-1:0] remain_x_ff, remain_y_ff, sample_x_ff, sample_y_ff;
   logic [7:0]  button_ff, latched_x_ff, latched_y_ff;
   logic [31:0] last_clock_ff;
   logic        rapid_phase_ff;
   logic [7:0]  port_a_ff, port_b_ff, port_c_ff, mode_ff;
   logic [1:0]  tshift_ff;
   logic        running_ff;
   logic [31:0] next_irq_ff;
   logic        irq_ff;
   logic [7:0]  rd_ff;
   logic [K_W-1:0]   k_ff;
   logic [KPROD_W-1:0] kprod_ff;
   logic [DIV_W-1:0] prod_ff;
   logic [SMP_W-1:0] dmag_x_ff, dmag_y_ff;
   logic [7:0]  rsp_read_data_ff;
   logic        rsp_irq_ff;

   logic [31:0] diff, period, since_irq;
   logic        diff_ok, is_write_c, latch_edge, read_a_upd;
   logic [7:0]  pc_in, bitset, rd_in, sel, btn_rd, pc_rd;
   logic [SMP_W-1:0] mag_sx, mag_sy, mag_rx, mag_ry;
   logic [DIV_W-1:0] div_dividend, quotient;
   logic [DVS_W-1:0] div_divisor, mc_eff;
   logic        div_done;
   logic signed [SMP_W:0] dx, dy;

   function automatic logic [SMP_W-1:0] mag(input logic signed [SMP_W-1:0] v);
      return v[SMP_W-1] ? SMP_W'(-v) : SMP_W'(v);
   endfunction

   function automatic logic [SMP_W-1:0] min_mag(input logic [DIV_W-1:0] q,
                                                input logic [SMP_W-1:0] r);
      return (q < DIV_W'(r)) ? q[SMP_W-1:0] : r;
   endfunction

   function automatic logic [7:0] clamp8(input logic [CNT_W-1:0] c);
      logic signed [CNT_W-1:0] v;
      v = c;
      if (v > $signed(CNT_W'(127)))       return 8'h7f;
      else if (v < $signed(-CNT_W'(128))) return 8'h80;
      else                                return c[7:0];
   endfunction

   function automatic logic signed [SMP_W:0] signed_share(
      input logic signed [SMP_W-1:0] s, input logic [SMP_W-1:0] m);
      return s[SMP_W-1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
   endfunction

   assign diff      = now_ff - last_clock_ff;
   assign diff_ok   = !diff[31] && (diff >= MOVE_MIN_CLOCKS);
   assign period    = 32'(cfg.intr_clock_period) << tshift_ff;
   assign since_irq = now_ff - next_irq_ff;

   always_comb begin
      bitset = port_c_ff;
      bitset[data_ff[3:1]] = data_ff[0];
   end

   assign is_write_c = (cmd_ff == CMD_WRITE) && ((port_ff == PORT_C) || (port_ff == PORT_CTRL));
   assign pc_in      = (port_ff == PORT_C) ? data_ff : (data_ff[7] ? 8'h00 : bitset);
   assign latch_edge = is_write_c && pc_in[7] && !port_c_ff[7];
   assign read_a_upd = (cmd_ff == CMD_READ) && (port_ff == PORT_A) && mode_ff[4];

   assign stat.need_update = (latch_edge || read_a_upd) && diff_ok;
   assign stat.div_done    = div_done;

   assign mag_sx = mag(sample_x_ff);
   assign mag_sy = mag(sample_y_ff);
   assign mag_rx = mag(remain_x_ff);
   assign mag_ry = mag(remain_y_ff);
   assign mc_eff = (cfg.move_clock_period == '0) ? DVS_W'(1) : cfg.move_clock_period;
   assign div_dividend = prod_ff;
   assign div_divisor  = mc_eff;
   assign dx = signed_share(sample_x_ff, dmag_x_ff);
   assign dy = signed_share(sample_y_ff, dmag_y_ff);

   bmpi_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (quotient),
      .done     (div_done)
   );

   // read muxes
   always_comb begin
      btn_rd = button_ff;
      if (cfg.rapid_enable && rapid_phase_ff) btn_rd = btn_rd | RAPID_BITS;
      if (port_c_ff[7]) sel = port_c_ff[6] ? latched_y_ff : latched_x_ff;
      else              sel = port_c_ff[6] ? count_y_ff[7:0] : count_x_ff[7:0];
      pc_rd = port_c_ff;
      if (mode_ff[3]) pc_rd = pc_rd & PORTC_LOW_MASK;
      if (mode_ff[0]) begin
         pc_rd = (pc_rd & 8'hf0) | PORTC_FIXED;
         pc_rd = pc_rd | ((cfg.dip_switch_two >> 5) & 8'h04);
         pc_rd = pc_rd | (((~cfg.dip_switch_zero) >> 4) & 8'h03);
      end
      rd_in = 8'h00;
      if (cmd_ff == CMD_READ) begin
         unique case (port_ff)
            PORT_A: begin
               if (mode_ff[4])
                  rd_in = (btn_rd & 8'hf0) | PORTA_FIXED |
                          (port_c_ff[5] ? {4'h0, sel[7:4]} : {4'h0, sel[3:0]});
               else
                  rd_in = port_a_ff;
            end
            PORT_B:  rd_in = mode_ff[1] ? PORTB_FIXED : port_b_ff;
            PORT_C:  rd_in = pc_rd;
            default: rd_in = OPEN_BUS;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff  <= in_command;
         port_ff <= in_port_select;
         data_ff <= in_write_data;
         now_ff  <= in_now;
         mx_ff   <= in_motion_x;
         my_ff   <= in_motion_y;
         btn_ff  <= in_buttons;
      end
      if (cmd.div_k)
         kprod_ff <= KPROD_W'(diff[30:K_PRE_SHIFT]) * KPROD_W'(K_RECIP);
      if (cmd.lat_k) k_ff <= kprod_ff[K_POST_SHIFT +: K_W];
      if (cmd.mul_x) prod_ff <= DIV_W'(mag_sx) * DIV_W'(k_ff);
      if (cmd.mul_y) prod_ff <= DIV_W'(mag_sy) * DIV_W'(k_ff);
      if (cmd.lat_x) dmag_x_ff <= min_mag(quotient, mag_rx);
      if (cmd.lat_y) dmag_y_ff <= min_mag(quotient, mag_ry);
      if (cmd.exec)  rd_ff <= rd_in;
      if (cmd.out_load) begin
         rsp_read_data_ff <= rd_ff;
         rsp_irq_ff       <= irq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_x_ff     <= '0;
         count_y_ff     <= '0;
         remain_x_ff    <= '0;
         remain_y_ff    <= '0;
         sample_x_ff    <= '0;
         sample_y_ff    <= '0;
         button_ff      <= '0;
         latched_x_ff   <= 8'hff;
         latched_y_ff   <= 8'hff;
         last_clock_ff  <= '0;
         rapid_phase_ff <= 1'b0;
         port_a_ff      <= '0;
         port_b_ff      <= '0;
         port_c_ff      <= PORTC_RESET;
         mode_ff        <= MODE_RESET;
         tshift_ff      <= '0;
         running_ff     <= 1'b0;
         next_irq_ff    <= '0;
         irq_ff         <= 1'b0;
      end else begin
         if (cmd.timer) begin
            irq_ff <= 1'b0;
            if (running_ff && !since_irq[31]) begin
               if (!port_c_ff[4]) begin
                  irq_ff      <= 1'b1;
                  next_irq_ff <= next_irq_ff + period;
               end else begin
                  running_ff <= 1'b0;
               end
            end
         end
         if (cmd.apply) begin
            rapid_phase_ff <= ~rapid_phase_ff;
            count_x_ff     <= count_x_ff + CNT_W'(dx);
            count_y_ff     <= count_y_ff + CNT_W'(dy);
            remain_x_ff    <= SMP_W'(remain_x_ff - dx);
            remain_y_ff    <= SMP_W'(remain_y_ff - dy);
            last_clock_ff  <= last_clock_ff + 32'(k_ff) * 32'(CLOCKS_PER_K);
         end
         if (cmd.exec) begin
            case (cmd_ff)
               CMD_WRITE: begin
                  case (port_ff)
                     PORT_A:    port_a_ff <= data_ff;
                     PORT_B:    port_b_ff <= data_ff;
                     PORT_TIME: tshift_ff <= data_ff[1:0];
                     default:   ;
                  endcase
                  if (is_write_c) begin
                     if ((port_ff == PORT_CTRL) && data_ff[7]) mode_ff <= data_ff;
                     if (latch_edge) begin
                        latched_x_ff <= clamp8(count_x_ff);
                        latched_y_ff <= clamp8(count_y_ff);
                        count_x_ff   <= '0;
                        count_y_ff   <= '0;
                     end
                     if (port_c_ff[4] && !pc_in[4] && !running_ff) begin
                        irq_ff      <= 1'b1;
                        running_ff  <= 1'b1;
                        next_irq_ff <= now_ff + period;
                     end
                     port_c_ff <= pc_in;
                  end
               end
               CMD_MOTION: begin
                  count_x_ff    <= count_x_ff + CNT_W'(remain_x_ff);
                  count_y_ff    <= count_y_ff + CNT_W'(remain_y_ff);
                  sample_x_ff   <= mx_ff;
                  sample_y_ff   <= my_ff;
                  remain_x_ff   <= mx_ff;
                  remain_y_ff   <= my_ff;
                  button_ff     <= btn_ff;
                  last_clock_ff <= now_ff;
               end
               default: ;
            endcase
         end
      end
   end

   assign out_read_data = rsp_read_data_ff;
   assign out_irq       = rsp_irq_ff;

endmodule

/* rtl/core/bmpi_ctrl.sv */
// Controller: sequences one transaction through timer, motion update and command.
`timescale 1ns / 1ps
module bmpi_ctrl
   import bmpi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_TIMER, ST_CHECK, ST_WAIT_K, ST_MUL_X, ST_DIV_X, ST_WAIT_X,
      ST_MUL_Y, ST_DIV_Y, ST_WAIT_Y, ST_APPLY, ST_EXEC, ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) begin
            cmd.load = 1'b1;
            state_in = ST_TIMER;
         end
         ST_TIMER: begin
            cmd.timer = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            if (stat.need_update) begin
               cmd.div_k = 1'b1;
               state_in  = ST_WAIT_K;
            end else begin
               state_in = ST_EXEC;
            end
         end
         ST_WAIT_K: begin
            cmd.lat_k = 1'b1;
            state_in  = ST_MUL_X;
         end
         ST_MUL_X: begin
            cmd.mul_x = 1'b1;
            state_in  = ST_DIV_X;
         end
         ST_DIV_X: begin
            cmd.div_start = 1'b1;
            state_in      = ST_WAIT_X;
         end
         ST_WAIT_X: if (stat.div_done) begin
            cmd.lat_x = 1'b1;
            state_in  = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            cmd.mul_y = 1'b1;
            state_in  = ST_DIV_Y;
         end
         ST_DIV_Y: begin
            cmd.div_start = 1'b1;
            state_in      = ST_WAIT_Y;
         end
         ST_WAIT_Y: if (stat.div_done) begin
            cmd.lat_y = 1'b1;
            state_in  = ST_APPLY;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: if (out_free) begin
            cmd.out_load = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.out_load)    rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_TIMER))
      else $error("accepted transaction did not start the sequence");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      stat.div_done |-> (state_ff == ST_WAIT_K || state_ff == ST_WAIT_X ||
                         state_ff == ST_WAIT_Y))
      else $error("divider finished outside a wait state");

   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_OUT))
      else $error("result overwritten while previous one is stalled");

endmodule

/* rtl/core/bus_mouse_ppi_interface.sv */
// Top level of the bus-mouse PPI interface: register port and block wiring.
//
// Input channel req_*: one transaction per bus read, bus write, motion sample
// or time tick, taken when req_valid is high and req_stall is low. Every
// transaction produces exactly one result on rsp_* (read_data, irq), taken
// when rsp_valid is high and rsp_stall is low.
// One transaction is handled at a time. Without a motion update the
// sequencer runs the timer, check, command and output states; rsp_valid
// rises in the same cycle as the sequencer is idle again and can accept the
// next transaction. A port A read in mouse mode or a latch write that finds
// 2000 or more clocks elapsed forms elapsed/1000 by a reciprocal multiply,
// then runs one division per axis on the shared one-bit-per-cycle divider.
// req_stall is low whenever the sequencer is idle, even while a result is
// still waiting in the output register; a held rsp_stall keeps that result
// and the next one waits inside the block until the register frees.
// Reset (synchronous, active high) restores all ports, counters, the timer
// and the config registers to power-up values; no clearing pass is needed.
// Registers are written through psel/penable/pwrite at byte address 4*index
// and should only change while the block is idle.
`timescale 1ns / 1ps
module bus_mouse_ppi_interface
   import bmpi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [2:0]  req_port_select,
   input  logic [7:0]  req_write_data,
   input  logic [31:0] req_now,
   input  logic signed [11:0] req_motion_x,
   input  logic signed [11:0] req_motion_y,
   input  logic [7:0]  req_buttons,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_irq,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type     cfg_ff;
   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        wr_en;
   logic [2:0]  reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rapid_enable      <= 1'b0;
         cfg_ff.move_clock_period <= 16'd354;
         cfg_ff.intr_clock_period <= 24'd166400;
         cfg_ff.dip_switch_two    <= '0;
         cfg_ff.dip_switch_zero   <= '0;
      end else if (wr_en) begin
         case (reg_idx)
            REG_RAPID: cfg_ff.rapid_enable      <= pwdata[0];
            REG_MOVE:  cfg_ff.move_clock_period <= pwdata[15:0];
            REG_INTR:  cfg_ff.intr_clock_period <= pwdata[23:0];
            REG_DIP2:  cfg_ff.dip_switch_two    <= pwdata[7:0];
            REG_DIP0:  cfg_ff.dip_switch_zero   <= pwdata[7:0];
            default:   ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_RAPID: prdata = 32'(cfg_ff.rapid_enable);
         REG_MOVE:  prdata = 32'(cfg_ff.move_clock_period);
         REG_INTR:  prdata = 32'(cfg_ff.intr_clock_period);
         REG_DIP2:  prdata = 32'(cfg_ff.dip_switch_two);
         REG_DIP0:  prdata = 32'(cfg_ff.dip_switch_zero);
         default:   prdata = '0;
      endcase
   end

   bmpi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   bmpi_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .cmd            (cmd),
      .stat           (stat),
      .in_command     (req_command),
      .in_port_select (req_port_select),
      .in_write_data  (req_write_data),
      .in_now         (req_now),
      .in_motion_x    (req_motion_x),
      .in_motion_y    (req_motion_y),
      .in_buttons     (req_buttons),
      .out_read_data  (rsp_read_data),
      .out_irq        (rsp_irq)
   );

endmodule
